FILE: src/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants for the generational handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int GEN_W       = 32;
    localparam int KIND_W      = 5;
    localparam int LIVE_W      = 7;

    localparam logic [GEN_W-1:0] FIRST_GENERATION = GEN_W'(1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_CLOSE  = 2'd2;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_INVALID      = 3'd1;
    localparam logic [2:0] ST_STALE        = 3'd2;
    localparam logic [2:0] ST_WRONG_KIND   = 3'd3;
    localparam logic [2:0] ST_CLOSED       = 3'd4;
    localparam logic [2:0] ST_CLOSE_FAILED = 3'd5;
    localparam logic [2:0] ST_FULL         = 3'd6;

    typedef struct packed {
        logic [1:0]        operation;
        logic [31:0]       slot_index;
        logic [GEN_W-1:0]  slot_generation;
        logic [KIND_W-1:0] resource_kind;
        logic              is_owned;
        logic              close_ok;
    } t_in_word;

    typedef struct packed {
        logic [2:0]        status;
        logic [IDX_W-1:0]  handle_index;
        logic [GEN_W-1:0]  handle_generation;
        logic [KIND_W-1:0] found_kind;
        logic              found_owned;
        logic [LIVE_W-1:0] live_count;
    } t_out_word;

    typedef struct packed {
        logic [GEN_W-1:0]  gen;
        logic [KIND_W-1:0] kind;
        logic              owned;
    } t_slot_ent;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_ght_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_ght_sts;

endpackage

`default_nettype wire

FILE: src/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// Controller: takes an input word, then commits it once the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  ght_pkg::t_ght_sts  i_sts,
    output ght_pkg::t_ght_cmd  o_cmd
);
    import ght_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: src/ght_datapath.sv
// ----------------------------------------------------------------------------
// ght_datapath
// Slot flags, slot memory, handle checks, live count and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  ght_pkg::t_in_word  i_in,
    input  ght_pkg::t_ght_cmd  i_cmd,
    output ght_pkg::t_ght_sts  o_sts,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ght_pkg::t_out_word o_out
);
    import ght_pkg::*;

    logic [TABLE_DEPTH-1:0] r_occ;
    logic [TABLE_DEPTH-1:0] r_closed;
    logic [LIVE_W-1:0]      r_live;
    logic                   r_out_valid;
    t_out_word              r_out;

    t_slot_ent              mem [TABLE_DEPTH];
    t_slot_ent              r_rd;

    t_in_word               r_item;
    logic [IDX_W-1:0]       r_addr;
    logic                   r_found;
    logic                   r_in_range;

    logic [TABLE_DEPTH-1:0] free_vec;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       rd_addr;

    logic                   occ;
    logic                   cls;
    logic [GEN_W-1:0]       cur_gen;
    logic [GEN_W-1:0]       nxt_gen;
    logic [2:0]             chk_status;
    logic [2:0]             n_status;
    logic                   do_insert;
    logic                   do_close;
    t_out_word              n_out;

    // lowest free or closed slot
    assign free_vec = ~r_occ | r_closed;

    always_comb begin
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign rd_addr = (i_in.operation == OP_INSERT) ? free_idx
                                                   : i_in.slot_index[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item     <= i_in;
            r_addr     <= rd_addr;
            r_found    <= |free_vec;
            r_in_range <= (i_in.slot_index < 32'(TABLE_DEPTH));
            r_rd       <= mem[rd_addr];
        end
        if (i_cmd.exec && do_insert) begin
            mem[r_addr] <= '{gen: nxt_gen, kind: r_item.resource_kind,
                             owned: r_item.is_owned};
        end
    end

    assign occ     = r_occ[r_addr];
    assign cls     = r_closed[r_addr];
    assign cur_gen = occ ? r_rd.gen : '0;

    always_comb begin
        nxt_gen = cur_gen + GEN_W'(1);
        if (nxt_gen == '0) begin
            nxt_gen = FIRST_GENERATION;
        end
    end

    always_comb begin
        if (r_item.slot_generation == '0 || !r_in_range || !occ) begin
            chk_status = ST_INVALID;
        end else if (r_rd.gen != r_item.slot_generation) begin
            chk_status = ST_STALE;
        end else if (cls) begin
            chk_status = ST_CLOSED;
        end else if (r_item.resource_kind != '0 && r_rd.kind != r_item.resource_kind) begin
            chk_status = ST_WRONG_KIND;
        end else begin
            chk_status = ST_OK;
        end
    end

    always_comb begin
        n_status  = ST_INVALID;
        do_insert = 1'b0;
        do_close  = 1'b0;
        unique case (r_item.operation)
            OP_INSERT: begin
                n_status  = r_found ? ST_OK : ST_FULL;
                do_insert = r_found;
            end
            OP_GET: begin
                n_status = chk_status;
            end
            OP_CLOSE: begin
                n_status = chk_status;
                if (chk_status == ST_OK) begin
                    if (r_rd.owned && !r_item.close_ok) begin
                        n_status = ST_CLOSE_FAILED;
                    end else begin
                        do_close = 1'b1;
                    end
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    always_comb begin
        n_out        = '0;
        n_out.status = n_status;
        if (do_insert) begin
            n_out.handle_index      = r_addr;
            n_out.handle_generation = nxt_gen;
        end
        if (r_item.operation == OP_GET && n_status == ST_OK) begin
            n_out.found_kind  = r_rd.kind;
            n_out.found_owned = r_rd.owned;
        end
        n_out.live_count = r_live;
        if (do_insert) begin
            n_out.live_count = r_live + LIVE_W'(1);
        end else if (do_close) begin
            n_out.live_count = r_live - LIVE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_closed    <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_live <= n_out.live_count;
                if (do_insert) begin
                    r_occ[r_addr]    <= 1'b1;
                    r_closed[r_addr] <= 1'b0;
                end else if (do_close) begin
                    r_closed[r_addr] <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    assign o_sts.out_blocked = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

endmodule

`default_nettype wire

FILE: src/generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Table of 64 slots addressed by (index, generation) handles.
//
// Input channel: i_in_valid / o_in_stall carry one request word (insert,
// get or close). Output channel: o_out_valid / i_out_stall carry one result
// word per request, in request order.
// A request is taken in the idle state, and the slot memory is read as it is
// taken; the exec state then checks the handle, writes the slot back and
// loads the output register once that register is free. A new request is
// taken only after the previous one has been committed, as the memory read
// is followed by the write-back of the same slot.
// While the receiver stalls, the result holds in the output register; one
// more request may be taken and then waits until that register frees up.
// Reset clears the occupied and closed flags, the live count and both
// channels' control state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  ght_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ght_pkg::t_out_word o_out
);
    import ght_pkg::*;

    t_ght_cmd cmd;
    t_ght_sts sts;

    ght_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ght_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: tb/tb_generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// tb_generational_handle_table_top
// Self-checking bench for the generational handle table.
//
// A shadow copy of the slot table predicts the result word of every request
// as it is accepted. Each result is compared field by field with the oldest
// pending prediction. The run has three parts: hand-picked requests covering
// every status but full, a pass that fills the table and runs it full, and a
// long random mix aimed mostly at live handles. Both channels idle and stall
// at random, apart from one stretch that runs at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_generational_handle_table_top;

    import ght_pkg::*;

    localparam logic [1:0] OP_UNKNOWN     = 2'd3;
    localparam int         IDLE_PCT       = 16;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         PEND_DEPTH     = 16;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_out_stall = 1'b0;
    t_in_word   i_in        = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out;

    // shadow slot table
    logic              shadow_used  [TABLE_DEPTH];
    logic              shadow_shut  [TABLE_DEPTH];
    logic [GEN_W-1:0]  shadow_gen   [TABLE_DEPTH];
    logic [KIND_W-1:0] shadow_kind  [TABLE_DEPTH];
    logic              shadow_owned [TABLE_DEPTH];
    logic [LIVE_W-1:0] shadow_live;

    // ring of predicted result words
    t_out_word pending_results [PEND_DEPTH];
    int        pend_head   = 0;
    int        pend_tail   = 0;
    int        err_count   = 0;
    int        idle_cycles = 0;
    logic      idle_en     = 1'b1;

    generational_handle_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // expected result word of one request; advances the shadow table
    function automatic t_out_word handle_table_result(input t_in_word w);
        t_out_word        res;
        logic [GEN_W-1:0] g;
        logic             taken;
        int               p;
        res   = '0;
        taken = 1'b0;
        p     = int'(w.slot_index[IDX_W-1:0]);
        case (w.operation)
            OP_INSERT: begin
                res.status = ST_FULL;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (!taken && (!shadow_used[i] || shadow_shut[i])) begin
                        g = shadow_gen[i] + 1'b1;
                        if (g == '0) g = FIRST_GENERATION;
                        shadow_gen[i]          = g;
                        shadow_kind[i]         = w.resource_kind;
                        shadow_owned[i]        = w.is_owned;
                        shadow_shut[i]         = 1'b0;
                        shadow_used[i]         = 1'b1;
                        shadow_live            = shadow_live + 1'b1;
                        res.status             = ST_OK;
                        res.handle_index       = IDX_W'(i);
                        res.handle_generation  = g;
                        taken                  = 1'b1;
                    end
                end
            end
            OP_GET, OP_CLOSE: begin
                if (w.slot_generation == '0 || w.slot_index >= TABLE_DEPTH
                        || !shadow_used[p]) begin
                    res.status = ST_INVALID;
                end else if (shadow_gen[p] != w.slot_generation) begin
                    res.status = ST_STALE;
                end else if (shadow_shut[p]) begin
                    res.status = ST_CLOSED;
                end else if (w.resource_kind != '0 && shadow_kind[p] != w.resource_kind) begin
                    res.status = ST_WRONG_KIND;
                end else if (w.operation == OP_GET) begin
                    res.status      = ST_OK;
                    res.found_kind  = shadow_kind[p];
                    res.found_owned = shadow_owned[p];
                end else if (shadow_owned[p] && !w.close_ok) begin
                    res.status = ST_CLOSE_FAILED;
                end else begin
                    res.status     = ST_OK;
                    shadow_shut[p] = 1'b1;
                    shadow_live    = shadow_live - 1'b1;
                end
            end
            default: res.status = ST_INVALID;
        endcase
        res.live_count = shadow_live;
        return res;
    endfunction

    function automatic t_in_word mk_word(input logic [1:0] op, input logic [31:0] idx,
                                         input logic [GEN_W-1:0] gen,
                                         input logic [KIND_W-1:0] kind,
                                         input logic owned, input logic cok);
        t_in_word w;
        w.operation       = op;
        w.slot_index      = idx;
        w.slot_generation = gen;
        w.resource_kind   = kind;
        w.is_owned        = owned;
        w.close_ok        = cok;
        return w;
    endfunction

    // random slot, biased toward live ones
    function automatic int pick_slot();
        int s;
        s = $urandom_range(TABLE_DEPTH - 1);
        for (int n = 0; n < 8 && !(shadow_used[s] && !shadow_shut[s]); n++)
            s = $urandom_range(TABLE_DEPTH - 1);
        return s;
    endfunction

    // send one request word; predict its result once accepted
    task automatic send_word(input t_in_word w);
        if (idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (o_in_stall);
        pending_results[pend_tail % PEND_DEPTH] = handle_table_result(w);
        pend_tail++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pend_tail != pend_head) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_word(mk_word(OP_GET,     32'd0,        32'd0,        5'd0,  1'b0, 1'b0));
        send_word(mk_word(OP_CLOSE,   32'd0,        32'd1,        5'd0,  1'b0, 1'b1));
        send_word(mk_word(OP_UNKNOWN, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'd31, 1'b1, 1'b1));
        send_word(mk_word(OP_INSERT,  32'd0,        32'd0,        5'd0,  1'b0, 1'b0));
        send_word(mk_word(OP_INSERT,  32'd0,        32'd0,        5'd20, 1'b1, 1'b0));
        send_word(mk_word(OP_INSERT,  32'd0,        32'd0,        5'd31, 1'b1, 1'b0));
        send_word(mk_word(OP_GET,     32'd0,        32'd1,        5'd0,  1'b0, 1'b0));
        send_word(mk_word(OP_GET,     32'd1,        32'd1,        5'd20, 1'b0, 1'b0));
        send_word(mk_word(OP_GET,     32'd2,        32'd1,        5'd31, 1'b0, 1'b0));
        send_word(mk_word(OP_GET,     32'd1,        32'd1,        5'd5,  1'b0, 1'b0));
        send_word(mk_word(OP_GET,     32'd1,        32'd2,        5'd0,  1'b0, 1'b0));
        send_word(mk_word(OP_GET,     32'd0,        32'hFFFFFFFF, 5'd0,  1'b0, 1'b0));
        send_word(mk_word(OP_GET,     32'd64,       32'd1,        5'd0,  1'b0, 1'b0));
        send_word(mk_word(OP_GET,     32'hFFFFFFFF, 32'hFFFFFFFF, 5'd0,  1'b0, 1'b0));
        // owned slot, external close fails: slot stays open
        send_word(mk_word(OP_CLOSE,   32'd1,        32'd1,        5'd20, 1'b0, 1'b0));
        send_word(mk_word(OP_GET,     32'd1,        32'd1,        5'd0,  1'b0, 1'b0));
        // not owned: close_ok ignored
        send_word(mk_word(OP_CLOSE,   32'd0,        32'd1,        5'd0,  1'b1, 1'b0));
        send_word(mk_word(OP_CLOSE,   32'd0,        32'd1,        5'd0,  1'b0, 1'b1));
        send_word(mk_word(OP_GET,     32'd0,        32'd1,        5'd0,  1'b0, 1'b0));
        send_word(mk_word(OP_CLOSE,   32'd1,        32'd1,        5'd0,  1'b0, 1'b1));
        send_word(mk_word(OP_INSERT,  32'd0,        32'd0,        5'd7,  1'b0, 1'b0));
        send_word(mk_word(OP_GET,     32'd0,        32'd1,        5'd0,  1'b0, 1'b0));
        send_word(mk_word(OP_CLOSE,   32'd2,        32'd1,        5'd3,  1'b0, 1'b1));
        drain_results();
    endtask

    task automatic test_full_table();
        int n;
        int s;
        n = 0;
        while (shadow_live < TABLE_DEPTH) begin
            send_word(mk_word(OP_INSERT, 32'(n), 32'(n), KIND_W'($urandom_range(20)),
                              n[0], 1'b0));
            n++;
        end
        repeat (3) send_word(mk_word(OP_INSERT, '0, '0, 5'd9, 1'b1, 1'b1));
        s = -1;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (shadow_owned[i] && !shadow_shut[i]) s = i;
        if (s >= 0)
            send_word(mk_word(OP_CLOSE, 32'(s), shadow_gen[s], 5'd0, 1'b0, 1'b0));
        send_word(mk_word(OP_INSERT, '0, '0, 5'd4, 1'b0, 1'b0));
        for (int k = 0; k < 6; k++)
            send_word(mk_word(OP_CLOSE, 32'(k * 10 + 3), shadow_gen[k * 10 + 3], 5'd0,
                              1'b0, 1'b1));
        repeat (7) send_word(mk_word(OP_INSERT, '0, '0, KIND_W'($urandom_range(20)),
                                     1'($urandom_range(1)), 1'b0));
        drain_results();
    endtask

    task automatic test_random(input int count);
        t_in_word w;
        int       slot;
        int       r;
        for (int n = 0; n < count; n++) begin
            idle_en = !(n >= count / 3 && n < count / 3 + 120);
            r = $urandom_range(99);
            w.operation = r < 32 ? OP_INSERT : r < 64 ? OP_GET : r < 95 ? OP_CLOSE
                                                                          : OP_UNKNOWN;
            slot = pick_slot();
            r = $urandom_range(99);
            w.slot_index = r < 88 ? 32'(slot)
                         : r < 94 ? 32'($urandom_range(TABLE_DEPTH, 255)) : 32'($urandom());
            r = $urandom_range(99);
            w.slot_generation = r < 80 ? shadow_gen[slot]
                              : r < 88 ? shadow_gen[slot] + 1'b1
                              : r < 94 ? GEN_W'(0) : GEN_W'($urandom());
            r = $urandom_range(99);
            if (w.operation == OP_INSERT)
                w.resource_kind = r < 90 ? KIND_W'($urandom_range(20))
                                         : KIND_W'($urandom_range(21, 31));
            else
                w.resource_kind = r < 50 ? KIND_W'(0) : r < 80 ? shadow_kind[slot]
                                                               : KIND_W'($urandom_range(31));
            w.is_owned = 1'($urandom_range(1));
            w.close_ok = $urandom_range(99) < 70;
            send_word(w);
        end
        idle_en = 1'b1;
        drain_results();
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pend_tail == pend_head) begin
                report_mismatch("result word with no request pending");
            end else begin
                want = pending_results[pend_head % PEND_DEPTH];
                pend_head++;
                if (o_out.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_out.status, want.status));
                if (o_out.handle_index !== want.handle_index)
                    report_mismatch($sformatf("handle_index got %0d want %0d",
                                              o_out.handle_index, want.handle_index));
                if (o_out.handle_generation !== want.handle_generation)
                    report_mismatch($sformatf("handle_generation got %0h want %0h",
                                              o_out.handle_generation,
                                              want.handle_generation));
                if (o_out.found_kind !== want.found_kind)
                    report_mismatch($sformatf("found_kind got %0d want %0d",
                                              o_out.found_kind, want.found_kind));
                if (o_out.found_owned !== want.found_owned)
                    report_mismatch($sformatf("found_owned got %0b want %0b",
                                              o_out.found_owned, want.found_owned));
                if (o_out.live_count !== want.live_count)
                    report_mismatch($sformatf("live_count got %0d want %0d",
                                              o_out.live_count, want.live_count));
            end
        end
        i_out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shadow_used[i]  = 1'b0;
            shadow_shut[i]  = 1'b0;
            shadow_gen[i]   = '0;
            shadow_kind[i]  = '0;
            shadow_owned[i] = 1'b0;
        end
        shadow_live = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_table();
        test_random(450);

        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/ght_pkg.sv
src/ght_ctrl.sv
src/ght_datapath.sv
src/generational_handle_table_top.sv
tb/tb_generational_handle_table_top.sv
